// ----- rtl/core/usv_pkg.sv -----
// ----------------------------------------------------------------------------
// usv_pkg
// Types, constants and byte classification helpers for the UTF-8 stream
// validator.
// ----------------------------------------------------------------------------
package usv_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CodeW    = 31;
  localparam int unsigned PayloadW = 6;

  localparam logic [ByteW-1:0] ContMask   = 8'hc0;
  localparam logic [ByteW-1:0] ContTag    = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'he0;
  localparam logic [ByteW-1:0] Lead2Tag   = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Tag   = 8'he0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hf8;
  localparam logic [ByteW-1:0] Lead4Tag   = 8'hf0;
  localparam logic [ByteW-1:0] Lead5Mask  = 8'hfc;
  localparam logic [ByteW-1:0] Lead5Tag   = 8'hf8;
  localparam logic [ByteW-1:0] Lead6Mask  = 8'hfe;
  localparam logic [ByteW-1:0] Lead6Tag   = 8'hfc;
  localparam logic [ByteW-1:0] InvalidTag = 8'hfe;
  localparam logic [ByteW-1:0] Nul        = 8'h00;

  localparam logic [CodeW-1:0] MaxCodePoint = 31'h0010ffff;
  localparam logic [CodeW-1:0] SurrMask     = 31'h0000f800;
  localparam logic [CodeW-1:0] SurrTag      = 31'h0000d800;

  // Decoder state kept between bytes of one string.
  typedef struct packed {
    logic [CountW-1:0] bytes_expected;
    logic [ByteW-1:0]  lead_byte;
    logic [ByteW-1:0]  first_cont_byte;
    logic [CodeW-1:0]  code_point;
    logic              failed;
  } usv_state_t;

  // Result handed from the decoder to the output register.
  typedef struct packed {
    logic valid;
    logic ok;
  } usv_result_t;

  function automatic logic [CountW-1:0] cont_count(input logic [ByteW-1:0] b);
    logic [CountW-1:0] n;
    n = '0;
    if ((b & Lead2Mask) == Lead2Tag) begin
      n = 3'd1;
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      n = 3'd2;
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      n = 3'd3;
    end else if ((b & Lead5Mask) == Lead5Tag) begin
      n = 3'd4;
    end else if ((b & Lead6Mask) == Lead6Tag) begin
      n = 3'd5;
    end
    return n;
  endfunction

  function automatic logic [CodeW-1:0] lead_bits(input logic [ByteW-1:0] b);
    logic [CodeW-1:0] v;
    v = '0;
    if ((b & Lead2Mask) == Lead2Tag) begin
      v = {26'd0, b[4:0]};
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      v = {27'd0, b[3:0]};
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      v = {28'd0, b[2:0]};
    end else if ((b & Lead5Mask) == Lead5Tag) begin
      v = {29'd0, b[1:0]};
    end else if ((b & Lead6Mask) == Lead6Tag) begin
      v = {30'd0, b[0]};
    end
    return v;
  endfunction

  // Overlong, out-of-range and surrogate checks on a finished sequence.
  function automatic logic sequence_ok(input logic [ByteW-1:0] l,
                                       input logic [ByteW-1:0] c,
                                       input logic [CodeW-1:0] cp);
    logic ok;
    ok = 1'b1;
    if ((l & Lead6Mask) == Lead2Tag) ok = 1'b0;
    if (l == 8'he0 && (c & 8'h20) == 8'h00) ok = 1'b0;
    if (l == 8'hf0 && (c & 8'h30) == 8'h00) ok = 1'b0;
    if (l == 8'hf8 && (c & 8'h38) == 8'h00) ok = 1'b0;
    if (l == 8'hfc && (c & 8'h3c) == 8'h00) ok = 1'b0;
    if (cp > MaxCodePoint) ok = 1'b0;
    if ((cp & SurrMask) == SurrTag) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- rtl/core/usv_decoder.sv -----
// ----------------------------------------------------------------------------
// usv_decoder
// Holds the per-string decoder state and updates it for one byte per cycle in which fire_i is high.
// ----------------------------------------------------------------------------
module usv_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [usv_pkg::ByteW-1:0]     byte_i,
  output usv_pkg::usv_result_t          res_o
);

  usv_pkg::usv_state_t st_q, st_d;
  usv_pkg::usv_result_t res;

  logic                        is_cont;
  logic [usv_pkg::ByteW-1:0]   fc_new;
  logic [usv_pkg::CodeW-1:0]   cp_new;

  assign is_cont = (byte_i & usv_pkg::ContMask) == usv_pkg::ContTag;
  assign fc_new  = (st_q.bytes_expected == usv_pkg::cont_count(st_q.lead_byte)) ?
                   byte_i : st_q.first_cont_byte;
  assign cp_new  = {st_q.code_point[usv_pkg::CodeW-usv_pkg::PayloadW-1:0],
                    byte_i[usv_pkg::PayloadW-1:0]};

  always_comb begin
    st_d      = st_q;
    res.valid = 1'b0;
    res.ok    = 1'b0;
    if (fire_i) begin
      priority if (byte_i == usv_pkg::Nul) begin
        res.valid = 1'b1;
        res.ok    = !st_q.failed && (st_q.bytes_expected == '0);
        st_d      = '0;
      end else if (st_q.failed) begin
        st_d = st_q;
      end else if (st_q.bytes_expected != '0) begin
        if (!is_cont) begin
          st_d.failed         = 1'b1;
          st_d.bytes_expected = '0;
        end else begin
          st_d.first_cont_byte = fc_new;
          st_d.code_point      = cp_new;
          st_d.bytes_expected  = st_q.bytes_expected - 3'd1;
          if (st_q.bytes_expected == 3'd1 &&
              !usv_pkg::sequence_ok(st_q.lead_byte, fc_new, cp_new)) begin
            st_d.failed = 1'b1;
          end
        end
      end else if (!byte_i[usv_pkg::ByteW-1]) begin
        st_d = st_q;
      end else if (is_cont ||
                   (byte_i & usv_pkg::Lead6Mask) == usv_pkg::InvalidTag) begin
        st_d.failed = 1'b1;
      end else begin
        st_d.lead_byte       = byte_i;
        st_d.first_cont_byte = '0;
        st_d.code_point      = usv_pkg::lead_bits(byte_i);
        st_d.bytes_expected  = usv_pkg::cont_count(byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign res_o = res;

  // A failed string never waits for continuation bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.failed |-> st_q.bytes_expected == '0)
    else $error("failed string still expects continuation bytes");

  // No sequence is longer than six bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.bytes_expected <= 3'd5)
    else $error("continuation count out of range");

  // A terminator returns the decoder to its idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && byte_i == usv_pkg::Nul) |=> (st_q == '0))
    else $error("state not cleared after terminator");

  // A result appears exactly for a terminator transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid == (fire_i && byte_i == usv_pkg::Nul))
    else $error("result not tied to terminator");

endmodule

// ----- rtl/core/utf8_stream_validator_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// UTF-8 string validator: one byte per transfer, one result per terminator.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on its input channel and reports, for
// each zero byte, whether the string that it ends was valid UTF-8. A byte
// goes into an input register and is decoded from there; a terminator's
// result is loaded into the output register at the end of the cycle in
// which the terminator is decoded. Throughput is one byte per cycle; the
// input stalls only while a terminator sits in the input register and the
// output register still holds an earlier result that is not yet taken.
module utf8_stream_validator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [usv_pkg::ByteW-1:0]  text_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       valid_res_o
);

  logic                      s1_valid_q;
  logic [usv_pkg::ByteW-1:0] s1_byte_q;
  logic                      out_valid_q;
  logic                      res_q;
  logic                      s1_adv;
  logic                      in_fire;
  usv_pkg::usv_result_t      res;

  // A terminator needs the output register free before it can be decoded.
  assign s1_adv  = s1_valid_q &&
                   !(s1_byte_q == usv_pkg::Nul && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
    end
  end

  usv_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res.ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

  // Only a waiting terminator can hold up the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_byte_q == usv_pkg::Nul))
    else $error("input stalled without a blocked terminator");

  // A new result never overwrites one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a pending transfer");

  // A decoded terminator always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_byte_q == usv_pkg::Nul) |=> out_valid_q)
    else $error("terminator produced no result");

endmodule
